// ===== design/distance_vector_table_update_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DVTU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvtu check failed");

// Next-cycle implication, checked outside reset.
`define DVTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvtu check failed");

// Next-cycle implication that also covers the reset cycles.
`define DVTU_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dvtu check failed");

`endif

// ===== design/dvtu_pkg.sv =====
// ----------------------------------------------------------------------------
// dvtu_pkg
// Types, constants and command codes of the distance-vector route table.
// ----------------------------------------------------------------------------
`default_nettype none

package dvtu_pkg;

  localparam int MAX_ROUTERS = 8;
  localparam int IDX_W       = $clog2(MAX_ROUTERS);
  localparam int CNT_W       = $clog2(MAX_ROUTERS + 1);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int MAT_DEPTH   = MAX_ROUTERS * MAX_ROUTERS;
  localparam int POS_W       = 4;

  localparam logic [15:0]      INF_COST = 16'hFFFF;
  localparam logic [POS_W-1:0] POS_MAX  = 4'd15;

  // Request codes.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_VEC   = 2'd1;
  localparam logic [1:0] REQ_CRASH = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_SELF_SLOT = 1'b0;
  localparam logic CFG_ACTIVE    = 1'b1;

  // Matrix write data sources.
  localparam logic [1:0] SRC_COST = 2'd0;
  localparam logic [1:0] SRC_VBUF = 2'd1;
  localparam logic [1:0] SRC_BEST = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  slot;
    logic [15:0] node_id;
    logic [15:0] cost;
    logic [15:0] next_hop;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] route_cost;
    logic [15:0] next_hop_id;
    logic        sender_missing;
  } out_item_t;

  typedef struct packed {
    logic              latch;
    logic              load_wr;
    logic              crash_wr;
    logic              vec_entry;
    logic              vec_end;
    logic [IDX_W-1:0]  tbl_idx;
    logic              ram_rd;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic              ram_wr;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [1:0]        ram_wr_src;
    logic              cap_id_me;
    logic              cap_orig;
    logic              cap_a;
    logic              relax_step;
    logic              hop_wr;
    logic [IDX_W-1:0]  hop_wr_idx;
    logic              res_clr;
    logic              res_miss;
    logic              res_read;
    logic              out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [2:0]       slot;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             sid_vld;
    logic             id_match;
    logic             id_eq_me;
    logic             crashed;
    logic             le;
    logic             changed;
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] me;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/dvtu_ram.sv =====
// ----------------------------------------------------------------------------
// dvtu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dvtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dvtu_datapath.sv =====
// ----------------------------------------------------------------------------
// dvtu_datapath
// Tables, cost matrix, vector buffer, relaxation arithmetic and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module dvtu_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_idx,
  input  wire logic [3:0]          cfg_wdata,
  input  wire dvtu_pkg::in_item_t  in_data,
  input  wire dvtu_pkg::dp_cmd_t   cmd,
  output dvtu_pkg::dp_sts_t        sts,
  output dvtu_pkg::out_item_t      out_data
);
  import dvtu_pkg::*;

  logic [2:0]          self_r;
  logic [3:0]          active_r;
  in_item_t            item_r;
  logic [POS_W-1:0]    pos_r;
  logic [16:0]         sid_r;
  logic [15:0]         vbuf_r  [MAX_ROUTERS];
  logic [15:0]         id_r    [MAX_ROUTERS];
  logic [15:0]         hop_r   [MAX_ROUTERS];
  logic [MAX_ROUTERS-1:0] crash_r;
  logic [MAT_DEPTH-1:0]   vld_r;
  logic                rd_vld_r;
  logic [15:0]         id_me_r;
  logic [15:0]         a_r;
  logic [16:0]         best_r;
  logic [15:0]         orig_r;
  out_item_t           res_r;
  out_item_t           out_r;

  logic [15:0]         ram_q;
  logic [15:0]         rd_eff;
  logic [15:0]         ram_wdata;
  logic [16:0]         sum;
  logic [CNT_W-1:0]    n;
  logic [IDX_W-1:0]    me;
  logic [15:0]         id_sel;
  logic [15:0]         hop_sel;
  logic [15:0]         hop_new;

  assign n  = (active_r > CNT_W'(MAX_ROUTERS)) ? CNT_W'(MAX_ROUTERS) : CNT_W'(active_r);
  assign me = IDX_W'(self_r);

  assign id_sel  = id_r[cmd.tbl_idx];
  assign hop_sel = hop_r[cmd.tbl_idx];
  assign rd_eff  = rd_vld_r ? ram_q : INF_COST;
  assign sum     = {1'b0, a_r} + {1'b0, rd_eff};

  // The inherited hop is the neighbor itself when it is a direct route.
  assign hop_new = (best_r[15:0] == INF_COST) ? INF_COST :
                   ((hop_sel == id_sel) ? id_sel : hop_sel);

  always_comb begin
    case (cmd.ram_wr_src)
      SRC_COST: ram_wdata = item_r.cost;
      SRC_VBUF: ram_wdata = vbuf_r[cmd.tbl_idx];
      SRC_BEST: ram_wdata = best_r[15:0];
      default:  ram_wdata = INF_COST;
    endcase
  end

  dvtu_ram #(
    .WIDTH (16),
    .DEPTH (MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (cmd.ram_wr_addr),
    .wdata (ram_wdata),
    .re    (cmd.ram_rd),
    .raddr (cmd.ram_rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r   <= '0;
      active_r <= 4'd8;
      pos_r    <= '0;
      sid_r    <= '0;
      crash_r  <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      for (int k = 0; k < MAX_ROUTERS; k++) begin
        id_r[k]  <= '0;
        hop_r[k] <= INF_COST;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SELF_SLOT: self_r   <= cfg_wdata[2:0];
          CFG_ACTIVE:    active_r <= cfg_wdata;
          default:       self_r   <= self_r;
        endcase
      end
      if (cmd.ram_wr) begin
        vld_r[cmd.ram_wr_addr] <= 1'b1;
      end
      if (cmd.ram_rd) begin
        rd_vld_r <= vld_r[cmd.ram_rd_addr];
      end
      if (cmd.load_wr) begin
        id_r[item_r.slot]  <= item_r.node_id;
        hop_r[item_r.slot] <= item_r.next_hop;
      end
      if (cmd.crash_wr) begin
        crash_r[item_r.slot] <= 1'b1;
      end
      if (cmd.hop_wr) begin
        hop_r[cmd.hop_wr_idx] <= hop_new;
      end
      if (cmd.vec_entry) begin
        if ((pos_r < POS_W'(n)) && (item_r.cost == 16'd0)) begin
          sid_r <= {1'b1, item_r.node_id};
        end
        if (pos_r < POS_MAX) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
      if (cmd.vec_end) begin
        pos_r <= '0;
        sid_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.vec_entry && (pos_r < POS_W'(n))) begin
      vbuf_r[pos_r[IDX_W-1:0]] <= item_r.cost;
    end
    if (cmd.cap_id_me) begin
      id_me_r <= id_sel;
    end
    if (cmd.cap_orig) begin
      orig_r <= rd_eff;
      best_r <= {1'b0, rd_eff};
    end
    if (cmd.cap_a) begin
      a_r <= rd_eff;
    end
    if (cmd.relax_step && (sum <= best_r)) begin
      best_r <= sum;
    end
    if (cmd.res_clr) begin
      res_r <= '{route_cost: 16'd0, next_hop_id: INF_COST, sender_missing: 1'b0};
    end
    if (cmd.res_miss) begin
      res_r.sender_missing <= 1'b1;
    end
    if (cmd.res_read) begin
      res_r.route_cost  <= rd_eff;
      res_r.next_hop_id <= hop_sel;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    sts.req_type = item_r.req_type;
    sts.slot     = item_r.slot;
    sts.last     = item_r.last;
    sts.pos      = pos_r;
    sts.sid_vld  = sid_r[16];
    sts.id_match = (id_sel == sid_r[15:0]);
    sts.id_eq_me = (id_sel == id_me_r);
    sts.crashed  = crash_r[cmd.tbl_idx];
    sts.le       = (sum <= best_r);
    sts.changed  = (best_r != {1'b0, orig_r});
    sts.n        = n;
    sts.me       = me;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== design/dvtu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvtu_ctrl
// Sequencer: request decode, sender search, row write and relaxation walk.
// ----------------------------------------------------------------------------
`default_nettype none

module dvtu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dvtu_pkg::dp_sts_t sts,
  output dvtu_pkg::dp_cmd_t      cmd
);
  import dvtu_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_RD_WAIT   = 4'd2;
  localparam logic [3:0] S_SEARCH    = 4'd3;
  localparam logic [3:0] S_ROWWR     = 4'd4;
  localparam logic [3:0] S_REL_START = 4'd5;
  localparam logic [3:0] S_REL_I     = 4'd6;
  localparam logic [3:0] S_REL_ORIG  = 4'd7;
  localparam logic [3:0] S_REL_J     = 4'd8;
  localparam logic [3:0] S_REL_A     = 4'd9;
  localparam logic [3:0] S_REL_B     = 4'd10;
  localparam logic [3:0] S_REL_END   = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] found_r, found_nxt, nh_r, nh_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    nh_nxt        = nh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_clr = 1'b1;
        case (sts.req_type)
          REQ_LOAD: begin
            cmd.load_wr     = 1'b1;
            cmd.ram_wr      = 1'b1;
            cmd.ram_wr_addr = {sts.me, sts.slot};
            cmd.ram_wr_src  = SRC_COST;
            state_nxt       = S_DONE;
          end
          REQ_CRASH: begin
            cmd.crash_wr = 1'b1;
            state_nxt    = S_DONE;
          end
          REQ_READ: begin
            cmd.ram_rd      = 1'b1;
            cmd.ram_rd_addr = {sts.me, sts.slot};
            state_nxt       = S_RD_WAIT;
          end
          default: begin
            cmd.vec_entry = 1'b1;
            k_nxt         = '0;
            state_nxt     = sts.last ? S_SEARCH : S_DONE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.tbl_idx  = sts.slot;
        cmd.res_read = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SEARCH: begin
        cmd.tbl_idx = k_r[IDX_W-1:0];
        if (!sts.sid_vld || (k_r >= sts.n)) begin
          cmd.res_miss = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.id_match) begin
          found_nxt = k_r[IDX_W-1:0];
          i_nxt     = '0;
          state_nxt = S_ROWWR;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      S_ROWWR: begin
        cmd.tbl_idx = i_r[IDX_W-1:0];
        if ((i_r < sts.n) && (POS_W'(i_r) < sts.pos)) begin
          if (!sts.crashed) begin
            cmd.ram_wr      = 1'b1;
            cmd.ram_wr_addr = {found_r, i_r[IDX_W-1:0]};
            cmd.ram_wr_src  = SRC_VBUF;
          end
          i_nxt = i_r + CNT_W'(1);
        end else begin
          state_nxt = S_REL_START;
        end
      end
      S_REL_START: begin
        cmd.tbl_idx   = sts.me;
        cmd.cap_id_me = 1'b1;
        i_nxt         = '0;
        state_nxt     = S_REL_I;
      end
      S_REL_I: begin
        cmd.tbl_idx = i_r[IDX_W-1:0];
        if (i_r >= sts.n) begin
          state_nxt = S_DONE;
        end else if (sts.id_eq_me) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          cmd.ram_rd      = 1'b1;
          cmd.ram_rd_addr = {sts.me, i_r[IDX_W-1:0]};
          state_nxt       = S_REL_ORIG;
        end
      end
      S_REL_ORIG: begin
        cmd.cap_orig = 1'b1;
        j_nxt        = '0;
        nh_nxt       = '0;
        state_nxt    = S_REL_J;
      end
      S_REL_J: begin
        if (j_r >= sts.n) begin
          state_nxt = S_REL_END;
        end else if (j_r[IDX_W-1:0] == sts.me) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          cmd.ram_rd      = 1'b1;
          cmd.ram_rd_addr = {sts.me, j_r[IDX_W-1:0]};
          state_nxt       = S_REL_A;
        end
      end
      S_REL_A: begin
        cmd.cap_a       = 1'b1;
        cmd.ram_rd      = 1'b1;
        cmd.ram_rd_addr = {j_r[IDX_W-1:0], i_r[IDX_W-1:0]};
        state_nxt       = S_REL_B;
      end
      S_REL_B: begin
        cmd.relax_step = 1'b1;
        // Less-or-equal lets a later slot win a tie.
        if (sts.le) begin
          nh_nxt = j_r[IDX_W-1:0];
        end
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_REL_J;
      end
      S_REL_END: begin
        cmd.tbl_idx = nh_r;
        if (sts.changed) begin
          cmd.ram_wr      = 1'b1;
          cmd.ram_wr_addr = {sts.me, i_r[IDX_W-1:0]};
          cmd.ram_wr_src  = SRC_BEST;
          cmd.hop_wr      = 1'b1;
          cmd.hop_wr_idx  = i_r[IDX_W-1:0];
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_REL_I;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.vec_end   = (sts.req_type == REQ_VEC) && sts.last;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      found_r     <= '0;
      nh_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
      nh_r        <= nh_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/distance_vector_table_update.sv =====
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Distance-vector route table with sender row update and relaxation.
// ----------------------------------------------------------------------------
//  Channel | Signals                          | Transfer
//  --------+----------------------------------+-----------------------------
//  in      | in_valid, in_ready, in_data      | one request
//  out     | out_valid, out_ready, out_data   | one result per request
//  cfg     | cfg_we, cfg_idx, cfg_wdata       | register write, no wait
//
//  Load, crash and non-final vector requests go through decode and done;
//  reads add a read-wait state. A final entry adds a sender search over the
//  table, a write of the sender row, a setup state and the relaxation walk,
//  which the single matrix read port serialises.
//  Reset is synchronous; the matrix reads as unreachable until written.
//  A new request is taken while the previous result still waits on out.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_table_update (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dvtu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dvtu_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_idx,
  input  wire logic [3:0]          cfg_wdata
);
  import dvtu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dvtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dvtu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/dvtu_checker.sv =====
// ----------------------------------------------------------------------------
// dvtu_checker
// Port-level checks on the route table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_table_update_defines.svh"

module dvtu_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire dvtu_pkg::out_item_t out_data
);
  import dvtu_pkg::*;

  // A result that is not taken stays offered.
  `DVTU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // After a request transfer the block is busy in the following cycle.
  `DVTU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Reset leaves no result pending.
  `DVTU_ASSERT_RST(a_reset_clear, !rst_n, !out_valid)

  // A result appears only after the block has gone busy.
  `DVTU_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(!in_ready))

endmodule

bind distance_vector_table_update dvtu_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
